>>> src/atk_pkg.sv
// Package with the shared types, character codes and the helper function of the tokenizer.
package atk_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_ONE    = 8'h31;
  localparam logic [7:0] CH_SEVEN  = 8'h37;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_F  = 8'h66;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_F   = 8'h46;
  localparam logic [7:0] CH_LOW_X  = 8'h78;
  localparam logic [7:0] CH_UP_X   = 8'h58;

  typedef enum logic [2:0] {
    KIND_COLON,
    KIND_COMMA,
    KIND_LPAREN,
    KIND_RPAREN,
    KIND_DIRECTIVE,
    KIND_REGISTER,
    KIND_INTEGER,
    KIND_IDENT
  } kind_t;

  typedef enum logic [2:0] {
    PH_START,
    PH_SIGN,
    PH_ZERO,
    PH_HEXPFX,
    PH_HEX,
    PH_OCT,
    PH_DEC,
    PH_BAD
  } phase_t;

  typedef enum logic [1:0] {
    LEAD_OTHER,
    LEAD_DOT,
    LEAD_DOLLAR
  } lead_t;

  typedef struct packed {
    logic        space;
    logic        punct;
    kind_t       pkind;
    logic        dot;
    logic        dollar;
    logic        sign;
    logic        minus;
    logic        zero;
    logic        x;
    logic        dig19;
    logic        oct;
    logic        dec;
    logic        hex;
    logic [3:0]  digit;
    logic [15:0] line;
    logic        last;
  } char_class_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] token_line;
    logic [11:0] column;
    logic [5:0]  length;
    logic        ends_line;
    logic        last_of_item;
  } token_t;

  typedef struct packed {
    logic   two;
    token_t tok0;
    token_t tok1;
  } bundle_t;

  function automatic kind_t word_kind(lead_t lead, phase_t phase, logic ovf);
    kind_t k;
    if (lead == LEAD_DOT) begin
      k = KIND_DIRECTIVE;
    end else if (lead == LEAD_DOLLAR) begin
      k = KIND_REGISTER;
    end else if ((phase == PH_ZERO || phase == PH_HEX || phase == PH_OCT ||
                  phase == PH_DEC) && !ovf) begin
      k = KIND_INTEGER;
    end else begin
      k = KIND_IDENT;
    end
    return k;
  endfunction

endpackage

>>> src/atk_char_if.sv
// Interface for the character input channel.
interface atk_char_if;
  logic        valid;
  logic        ready;
  logic [7:0]  ch;
  logic [15:0] line_number;
  logic        line_last;

  modport source(output valid, ch, line_number, line_last, input ready);
  modport sink(input valid, ch, line_number, line_last, output ready);
endinterface

>>> src/atk_token_if.sv
// Interface for the token output channel.
interface atk_token_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [15:0] token_line;
  logic [11:0] column;
  logic [5:0]  length;
  logic        ends_line;
  logic        last_of_item;

  modport source(output valid, kind, token_line, column, length, ends_line, last_of_item,
                 input ready);
  modport sink(input valid, kind, token_line, column, length, ends_line, last_of_item,
               output ready);
endinterface

>>> src/atk_fifo.sv
// Small register-based queue with a combinational head.
module atk_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end
endmodule

>>> src/atk_front.sv
// Front end: accepts characters and classifies them for the back end.
module atk_front import atk_pkg::*; (
  atk_char_if.sink    chars,
  input  logic        queue_full,
  output logic        queue_push,
  output char_class_t queue_data
);
  logic [7:0] c;
  logic       is_lower_hex;
  logic       is_upper_hex;

  assign c = chars.ch;
  assign chars.ready = !queue_full;
  assign queue_push  = chars.valid && !queue_full;

  always_comb begin
    is_lower_hex = (c >= CH_LOW_A) && (c <= CH_LOW_F);
    is_upper_hex = (c >= CH_UP_A) && (c <= CH_UP_F);

    queue_data.space  = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR)) || (c == CH_NUL);
    queue_data.punct  = (c == CH_COLON) || (c == CH_COMMA) ||
                        (c == CH_LPAREN) || (c == CH_RPAREN);
    case (c)
      CH_COLON:  queue_data.pkind = KIND_COLON;
      CH_COMMA:  queue_data.pkind = KIND_COMMA;
      CH_LPAREN: queue_data.pkind = KIND_LPAREN;
      default:   queue_data.pkind = KIND_RPAREN;
    endcase
    queue_data.dot    = (c == CH_DOT);
    queue_data.dollar = (c == CH_DOLLAR);
    queue_data.sign   = (c == CH_PLUS) || (c == CH_MINUS);
    queue_data.minus  = (c == CH_MINUS);
    queue_data.zero   = (c == CH_ZERO);
    queue_data.x      = (c == CH_LOW_X) || (c == CH_UP_X);
    queue_data.dig19  = (c >= CH_ONE) && (c <= CH_NINE);
    queue_data.oct    = (c >= CH_ZERO) && (c <= CH_SEVEN);
    queue_data.dec    = (c >= CH_ZERO) && (c <= CH_NINE);
    queue_data.hex    = queue_data.dec || is_lower_hex || is_upper_hex;
    queue_data.digit  = queue_data.dec ? c[3:0] : c[3:0] + 4'd9;
    queue_data.line   = chars.line_number;
    queue_data.last   = chars.line_last;
  end
endmodule

>>> src/atk_back.sv
// Back end: word state, integer parsing, tokens; one character per cycle unless out_full.
module atk_back import atk_pkg::*; #(
  parameter int WORD_BUFFER_BYTES = 64,
  parameter int COLUMN_BITS       = 12,
  parameter int INTEGER_BITS      = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cls_empty,
  input  char_class_t cls,
  output logic        cls_pop,
  input  logic        out_full,
  output logic        out_push,
  output bundle_t     out_bundle
);
  localparam int LEN_W = $clog2(WORD_BUFFER_BYTES);
  localparam int ACC_W = INTEGER_BITS + 4;
  localparam logic [LEN_W-1:0]       KEEP_MAX = LEN_W'(WORD_BUFFER_BYTES - 1);
  localparam logic [COLUMN_BITS-1:0] COL_MAX  = '1;
  localparam logic [ACC_W-1:0]       HALF     = ACC_W'(1) << (INTEGER_BITS - 1);

  logic [COLUMN_BITS-1:0]  position;
  logic                    word_open;
  logic [COLUMN_BITS-1:0]  word_start;
  logic [LEN_W-1:0]        word_length;
  lead_t                   lead;
  phase_t                  phase;
  logic                    negative;
  logic [INTEGER_BITS-1:0] magnitude;
  logic                    overflowed;

  logic [COLUMN_BITS-1:0]  col;
  logic                    grow;
  logic                    starting;
  logic                    flush;
  logic                    last_word;
  logic [COLUMN_BITS-1:0]  s_start;
  logic [LEN_W-1:0]        s_len;
  lead_t                   s_lead;
  phase_t                  s_phase;
  logic                    s_neg;
  logic [INTEGER_BITS-1:0] s_mag;
  logic                    s_ovf;
  logic [LEN_W-1:0]        n_len;
  phase_t                  n_phase;
  logic                    n_neg;
  logic [INTEGER_BITS-1:0] n_mag;
  logic                    n_ovf;
  logic                    feed;
  logic                    do_acc;
  logic [1:0]              base_sel;
  logic [ACC_W-1:0]        wide_mag;
  logic [ACC_W-1:0]        sum;
  logic [ACC_W-1:0]        limit;
  token_t                  tok_a;
  token_t                  tok_p;
  token_t                  tok_l;
  logic [COLUMN_BITS+11:0] col_ext_a;
  logic [COLUMN_BITS+11:0] col_ext_p;
  logic [COLUMN_BITS+11:0] col_ext_l;
  logic [LEN_W+5:0]        len_ext_a;
  logic [LEN_W+5:0]        len_ext_l;

  localparam logic [1:0] BASE_8  = 2'd0;
  localparam logic [1:0] BASE_10 = 2'd1;
  localparam logic [1:0] BASE_16 = 2'd2;

  assign cls_pop = !cls_empty && !out_full;

  always_comb begin
    col       = (position != COL_MAX) ? position + 1'b1 : COL_MAX;
    grow      = !cls.space && !cls.punct;
    flush     = !grow && word_open;
    starting  = grow && !word_open;
    last_word = cls.last && grow;

    s_start = starting ? col : word_start;
    s_len   = starting ? '0 : word_length;
    if (starting) begin
      s_lead = cls.dot ? LEAD_DOT : (cls.dollar ? LEAD_DOLLAR : LEAD_OTHER);
    end else begin
      s_lead = lead;
    end
    s_phase = starting ? PH_START : phase;
    s_neg   = starting ? 1'b0 : negative;
    s_mag   = starting ? '0 : magnitude;
    s_ovf   = starting ? 1'b0 : overflowed;

    feed  = grow && (s_len < KEEP_MAX) && (s_lead == LEAD_OTHER);
    n_len = (grow && (s_len < KEEP_MAX)) ? s_len + 1'b1 : s_len;

    n_phase  = s_phase;
    n_neg    = s_neg;
    do_acc   = 1'b0;
    base_sel = BASE_10;
    case (s_phase)
      PH_START, PH_SIGN: begin
        if (s_phase == PH_START && cls.sign) begin
          n_neg   = cls.minus;
          n_phase = PH_SIGN;
        end else if (cls.zero) begin
          n_phase = PH_ZERO;
        end else if (cls.dig19) begin
          n_phase = PH_DEC;
          do_acc  = 1'b1;
        end else begin
          n_phase = PH_BAD;
        end
      end
      PH_ZERO: begin
        if (cls.x) begin
          n_phase = PH_HEXPFX;
        end else if (cls.oct) begin
          n_phase  = PH_OCT;
          do_acc   = 1'b1;
          base_sel = BASE_8;
        end else begin
          n_phase = PH_BAD;
        end
      end
      PH_HEXPFX, PH_HEX: begin
        if (cls.hex) begin
          n_phase  = PH_HEX;
          do_acc   = 1'b1;
          base_sel = BASE_16;
        end else begin
          n_phase = PH_BAD;
        end
      end
      PH_OCT: begin
        if (cls.oct) begin
          do_acc   = 1'b1;
          base_sel = BASE_8;
        end else begin
          n_phase = PH_BAD;
        end
      end
      PH_DEC: begin
        if (cls.dec) begin
          do_acc = 1'b1;
        end else begin
          n_phase = PH_BAD;
        end
      end
      default: n_phase = PH_BAD;
    endcase

    wide_mag = ACC_W'(s_mag);
    case (base_sel)
      BASE_8:  sum = (wide_mag << 3) + ACC_W'(cls.digit);
      BASE_16: sum = (wide_mag << 4) + ACC_W'(cls.digit);
      default: sum = (wide_mag << 3) + (wide_mag << 1) + ACC_W'(cls.digit);
    endcase
    limit = HALF - ACC_W'(!n_neg);

    n_mag = s_mag;
    n_ovf = s_ovf;
    if (do_acc && !s_ovf) begin
      if (sum > limit) begin
        n_ovf = 1'b1;
      end else begin
        n_mag = sum[INTEGER_BITS-1:0];
      end
    end
    if (!feed) begin
      n_phase = s_phase;
      n_neg   = s_neg;
      n_mag   = s_mag;
      n_ovf   = s_ovf;
    end

    col_ext_a = {12'd0, word_start};
    col_ext_p = {12'd0, col};
    col_ext_l = {12'd0, s_start};
    len_ext_a = {6'd0, word_length};
    len_ext_l = {6'd0, n_len};

    tok_a.kind         = word_kind(lead, phase, overflowed);
    tok_a.token_line   = cls.line;
    tok_a.column       = col_ext_a[11:0];
    tok_a.length       = len_ext_a[5:0];
    tok_a.ends_line    = 1'b0;
    tok_a.last_of_item = 1'b0;

    tok_p.kind         = cls.pkind;
    tok_p.token_line   = cls.line;
    tok_p.column       = col_ext_p[11:0];
    tok_p.length       = 6'd1;
    tok_p.ends_line    = 1'b0;
    tok_p.last_of_item = 1'b0;

    tok_l.kind         = word_kind(s_lead, n_phase, n_ovf);
    tok_l.token_line   = cls.line;
    tok_l.column       = col_ext_l[11:0];
    tok_l.length       = len_ext_l[5:0];
    tok_l.ends_line    = 1'b0;
    tok_l.last_of_item = 1'b0;

    out_bundle.two  = flush && cls.punct;
    out_bundle.tok1 = tok_p;
    if (flush) begin
      out_bundle.tok0 = tok_a;
    end else if (cls.punct) begin
      out_bundle.tok0 = tok_p;
    end else begin
      out_bundle.tok0 = tok_l;
    end
    if (out_bundle.two) begin
      out_bundle.tok1.ends_line    = cls.last;
      out_bundle.tok1.last_of_item = 1'b1;
    end else begin
      out_bundle.tok0.ends_line    = cls.last;
      out_bundle.tok0.last_of_item = 1'b1;
    end

    out_push = cls_pop && (flush || cls.punct || last_word);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position    <= '0;
      word_open   <= 1'b0;
      word_start  <= '0;
      word_length <= '0;
      lead        <= LEAD_OTHER;
      phase       <= PH_START;
      negative    <= 1'b0;
      magnitude   <= '0;
      overflowed  <= 1'b0;
    end else if (cls_pop) begin
      if (cls.last) begin
        position <= '0;
      end else if (position != COL_MAX) begin
        position <= position + 1'b1;
      end
      if (cls.last || !grow) begin
        word_open   <= 1'b0;
        word_start  <= '0;
        word_length <= '0;
        lead        <= LEAD_OTHER;
        phase       <= PH_START;
        negative    <= 1'b0;
        magnitude   <= '0;
        overflowed  <= 1'b0;
      end else begin
        word_open   <= 1'b1;
        word_start  <= s_start;
        word_length <= n_len;
        lead        <= s_lead;
        phase       <= n_phase;
        negative    <= n_neg;
        magnitude   <= n_mag;
        overflowed  <= n_ovf;
      end
    end
  end
endmodule

>>> src/atk_emit.sv
// Output stage: presents the one or two tokens of each queued bundle in order.
module atk_emit import atk_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        bundle_empty,
  input  bundle_t     bundle,
  output logic        bundle_pop,
  atk_token_if.source tokens
);
  logic   second;
  logic   fire;
  token_t tok;

  assign tok  = second ? bundle.tok1 : bundle.tok0;
  assign fire = tokens.valid && tokens.ready;

  assign tokens.valid        = !bundle_empty;
  assign tokens.kind         = tok.kind;
  assign tokens.token_line   = tok.token_line;
  assign tokens.column       = tok.column;
  assign tokens.length       = tok.length;
  assign tokens.ends_line    = tok.ends_line;
  assign tokens.last_of_item = tok.last_of_item;

  assign bundle_pop = fire && (second || !bundle.two);

  always_ff @(posedge clk) begin
    if (rst) begin
      second <= 1'b0;
    end else if (fire) begin
      second <= bundle.two && !second;
    end
  end
endmodule

>>> src/assembly_line_tokenizer_top.sv
// Top level of the assembly line tokenizer.
// A token is presented once the character that completes it has passed through the middle
// queue, the back end and the output queue.
// Throughput: one character per cycle while neither queue is full; a character that yields two
// tokens holds the output for both of them, and the four-entry queues absorb the difference.
// Reset: synchronous rst empties both queues and clears the column count and word state.
module assembly_line_tokenizer_top import atk_pkg::*; #(
  parameter int WORD_BUFFER_BYTES = 64,
  parameter int COLUMN_BITS       = 12,
  parameter int INTEGER_BITS      = 64
) (
  input logic         clk,
  input logic         rst,
  atk_char_if.sink    chars,
  atk_token_if.source tokens
);
  logic        mid_push;
  logic        mid_full;
  logic        mid_pop;
  logic        mid_empty;
  char_class_t mid_in;
  char_class_t mid_out;
  logic        out_push;
  logic        out_full;
  logic        out_pop;
  logic        out_empty;
  bundle_t     out_in;
  bundle_t     out_out;

  atk_front u_front (
    .chars      (chars),
    .queue_full (mid_full),
    .queue_push (mid_push),
    .queue_data (mid_in)
  );

  atk_fifo #(
    .WIDTH ($bits(char_class_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_mid_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (mid_push),
    .push_data (mid_in),
    .full      (mid_full),
    .pop       (mid_pop),
    .pop_data  (mid_out),
    .empty     (mid_empty)
  );

  atk_back #(
    .WORD_BUFFER_BYTES (WORD_BUFFER_BYTES),
    .COLUMN_BITS       (COLUMN_BITS),
    .INTEGER_BITS      (INTEGER_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cls_empty  (mid_empty),
    .cls        (mid_out),
    .cls_pop    (mid_pop),
    .out_full   (out_full),
    .out_push   (out_push),
    .out_bundle (out_in)
  );

  atk_fifo #(
    .WIDTH ($bits(bundle_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_out_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (out_push),
    .push_data (out_in),
    .full      (out_full),
    .pop       (out_pop),
    .pop_data  (out_out),
    .empty     (out_empty)
  );

  atk_emit u_emit (
    .clk          (clk),
    .rst          (rst),
    .bundle_empty (out_empty),
    .bundle       (out_out),
    .bundle_pop   (out_pop),
    .tokens       (tokens)
  );
endmodule

>>> tb/tb_assembly_line_tokenizer_top.sv
// Self-checking testbench that streams assembly lines into the tokenizer and checks every token.
`timescale 1ns / 1ps

module tb_assembly_line_tokenizer_top;
  import atk_pkg::*;

  localparam logic [11:0] COL_MAX      = 12'hFFF;
  localparam logic [5:0]  KEEP_MAX     = 6'd63;
  localparam logic [7:0]  CH_LF        = 8'h0A;
  localparam logic [7:0]  CH_VT        = 8'h0B;
  localparam logic [7:0]  CH_FF        = 8'h0C;
  localparam int          RANDOM_ITEMS = 720;
  localparam int          IDLE_LIMIT   = 4000;
  localparam int          DRAIN_CYCLES = 8;

  class lexer_scoreboard;
    logic [11:0] pos;
    logic        open;
    logic [11:0] start_col;
    logic [5:0]  wlen;
    lead_t       lead;
    phase_t      phase;
    logic        neg;
    logic [63:0] mag;
    logic        ovf;
    token_t      tokens_due[$];
    int          errors;

    function new();
      errors = 0;
      pos = '0;
      clear_word();
    endfunction

    function void clear_word();
      open = 1'b0;
      start_col = '0;
      wlen = '0;
      lead = LEAD_OTHER;
      phase = PH_START;
      neg = 1'b0;
      mag = '0;
      ovf = 1'b0;
    endfunction

    function logic [4:0] hex_value(logic [7:0] c);
      if (c >= CH_ZERO && c <= CH_NINE) return 5'(c - CH_ZERO);
      if (c >= CH_LOW_A && c <= CH_LOW_F) return 5'(c - CH_LOW_A + 8'd10);
      if (c >= CH_UP_A && c <= CH_UP_F) return 5'(c - CH_UP_A + 8'd10);
      return 5'd16;
    endfunction

    function void accumulate(logic [63:0] base, logic [4:0] d);
      logic [63:0] lim;
      if (ovf) return;
      lim = 64'h8000_0000_0000_0000 - (neg ? 64'd0 : 64'd1);
      if (mag > (lim - {59'd0, d}) / base) begin
        ovf = 1'b1;
      end else begin
        mag = mag * base + {59'd0, d};
      end
    endfunction

    function void feed_number(logic [7:0] c);
      logic [4:0] d;
      d = hex_value(c);
      case (phase)
        PH_START, PH_SIGN: begin
          if (phase == PH_START && (c == CH_PLUS || c == CH_MINUS)) begin
            neg = (c == CH_MINUS);
            phase = PH_SIGN;
          end else if (c == CH_ZERO) begin
            phase = PH_ZERO;
          end else if (c >= CH_ONE && c <= CH_NINE) begin
            phase = PH_DEC;
            accumulate(64'd10, d);
          end else begin
            phase = PH_BAD;
          end
        end
        PH_ZERO: begin
          if (c == CH_LOW_X || c == CH_UP_X) begin
            phase = PH_HEXPFX;
          end else if (c >= CH_ZERO && c <= CH_SEVEN) begin
            phase = PH_OCT;
            accumulate(64'd8, d);
          end else begin
            phase = PH_BAD;
          end
        end
        PH_HEXPFX, PH_HEX: begin
          if (d < 5'd16) begin
            phase = PH_HEX;
            accumulate(64'd16, d);
          end else begin
            phase = PH_BAD;
          end
        end
        PH_OCT: begin
          if (c >= CH_ZERO && c <= CH_SEVEN) accumulate(64'd8, d);
          else phase = PH_BAD;
        end
        PH_DEC: begin
          if (c >= CH_ZERO && c <= CH_NINE) accumulate(64'd10, d);
          else phase = PH_BAD;
        end
        default: phase = PH_BAD;
      endcase
    endfunction

    function token_t word_token(logic [15:0] ln);
      token_t t;
      if (lead == LEAD_DOT) t.kind = KIND_DIRECTIVE;
      else if (lead == LEAD_DOLLAR) t.kind = KIND_REGISTER;
      else if ((phase == PH_ZERO || phase == PH_HEX || phase == PH_OCT || phase == PH_DEC)
               && !ovf) t.kind = KIND_INTEGER;
      else t.kind = KIND_IDENT;
      t.token_line = ln;
      t.column = start_col;
      t.length = wlen;
      t.ends_line = 1'b0;
      t.last_of_item = 1'b0;
      return t;
    endfunction

    function void take_char(logic [7:0] c, logic [15:0] ln, logic lst);
      token_t      made[2];
      int          n;
      logic [11:0] col;
      logic        blank;
      logic        is_punct;
      kind_t       pk;
      n = 0;
      col = (pos < COL_MAX) ? pos + 12'd1 : COL_MAX;
      blank = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR) || (c == CH_NUL);
      is_punct = 1'b1;
      case (c)
        CH_COLON:  pk = KIND_COLON;
        CH_COMMA:  pk = KIND_COMMA;
        CH_LPAREN: pk = KIND_LPAREN;
        CH_RPAREN: pk = KIND_RPAREN;
        default: begin
          pk = KIND_COLON;
          is_punct = 1'b0;
        end
      endcase
      if ((blank || is_punct) && open) begin
        made[n] = word_token(ln);
        n++;
        clear_word();
      end
      if (is_punct) begin
        made[n].kind = pk;
        made[n].token_line = ln;
        made[n].column = col;
        made[n].length = 6'd1;
        made[n].ends_line = 1'b0;
        made[n].last_of_item = 1'b0;
        n++;
      end else if (!blank) begin
        if (!open) begin
          clear_word();
          open = 1'b1;
          start_col = col;
          if (c == CH_DOT) lead = LEAD_DOT;
          else if (c == CH_DOLLAR) lead = LEAD_DOLLAR;
        end
        if (wlen < KEEP_MAX) begin
          wlen++;
          if (lead == LEAD_OTHER) feed_number(c);
        end
      end
      if (lst && open) begin
        made[n] = word_token(ln);
        n++;
        clear_word();
      end
      if (pos < COL_MAX) pos++;
      if (lst) begin
        pos = '0;
        clear_word();
      end
      if (n > 0) begin
        made[n - 1].last_of_item = 1'b1;
        made[n - 1].ends_line = lst;
      end
      for (int i = 0; i < n; i++) tokens_due.push_back(made[i]);
    endfunction

    function void check_token(token_t got);
      token_t want;
      if (tokens_due.size() == 0) begin
        $error("token with none due: kind %0d line %0d column %0d length %0d",
               got.kind, got.token_line, got.column, got.length);
        errors++;
        return;
      end
      want = tokens_due.pop_front();
      if (got.kind !== want.kind) begin
        $error("kind: expected %0d, got %0d", want.kind, got.kind);
        errors++;
      end
      if (got.token_line !== want.token_line) begin
        $error("token_line: expected %0d, got %0d", want.token_line, got.token_line);
        errors++;
      end
      if (got.column !== want.column) begin
        $error("column: expected %0d, got %0d", want.column, got.column);
        errors++;
      end
      if (got.length !== want.length) begin
        $error("length: expected %0d, got %0d", want.length, got.length);
        errors++;
      end
      if (got.ends_line !== want.ends_line) begin
        $error("ends_line: expected %0d, got %0d", want.ends_line, got.ends_line);
        errors++;
      end
      if (got.last_of_item !== want.last_of_item) begin
        $error("last_of_item: expected %0d, got %0d", want.last_of_item, got.last_of_item);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  bit   calm = 1'b0;
  int   idle_cycles = 0;
  logic [7:0] line_text[$];
  lexer_scoreboard sb;

  atk_char_if  chars_if();
  atk_token_if tokens_if();

  assembly_line_tokenizer_top dut (
    .clk    (clk),
    .rst    (rst),
    .chars  (chars_if),
    .tokens (tokens_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic void add_byte(logic [7:0] b);
    line_text.push_back(b);
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) line_text.push_back(s[i]);
  endfunction

  function automatic logic [7:0] blank_byte();
    if ($urandom_range(0, 9) < 7) return CH_SPACE;
    case ($urandom_range(0, 5))
      0: return CH_TAB;
      1: return CH_LF;
      2: return CH_VT;
      3: return CH_FF;
      4: return CH_CR;
      default: return CH_NUL;
    endcase
  endfunction

  function automatic logic [7:0] word_byte(bit first);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 30) return 8'(CH_LOW_A + $urandom_range(0, 25));
    if (r < 45) return 8'(CH_UP_A + $urandom_range(0, 25));
    if (r < 70 && !first) return 8'(CH_ZERO + $urandom_range(0, 9));
    if (r < 80) return 8'h5F;
    if (r < 92) return 8'($urandom_range(128, 255));
    return 8'($urandom_range(33, 126));
  endfunction

  function automatic void add_word(logic [7:0] lead);
    int unsigned len;
    len = ($urandom_range(0, 24) == 0) ? $urandom_range(60, 80) : $urandom_range(1, 8);
    if (lead != CH_NUL) add_byte(lead);
    for (int i = 0; i < len; i++) add_byte(word_byte(i == 0 && lead == CH_NUL));
  endfunction

  function automatic string int_word();
    logic [63:0] m;
    string       s;
    string       sign;
    string       pfx;
    case ($urandom_range(0, 3))
      0: m = 64'($urandom_range(0, 1000));
      1: m = {$urandom, $urandom} >> $urandom_range(0, 63);
      2: m = 64'h8000_0000_0000_0000 + 64'($urandom_range(0, 6)) - 64'd3;
      default: m = {$urandom, $urandom};
    endcase
    case ($urandom_range(0, 3))
      0: sign = "-";
      1: sign = "+";
      default: sign = "";
    endcase
    case ($urandom_range(0, 2))
      0: s = $sformatf("%0d", m);
      1: begin
        pfx = $urandom_range(0, 1) ? "0x" : "0X";
        s = $sformatf("%s%0h", pfx, m);
        if ($urandom_range(0, 1)) s = s.toupper();
      end
      default: s = $sformatf("0%0o", m);
    endcase
    return {sign, s};
  endfunction

  function automatic string broken_number();
    case ($urandom_range(0, 9))
      0: return "+";
      1: return "-";
      2: return "0x";
      3: return "08";
      4: return "09";
      5: return "0x1g";
      6: return "--1";
      7: return "+0X";
      8: return "12a";
      default: return {int_word(), "z"};
    endcase
  endfunction

  function automatic void build_random_line();
    int unsigned pieces;
    int unsigned r;
    pieces = $urandom_range(1, 8);
    for (int p = 0; p < pieces; p++) begin
      r = $urandom_range(0, 99);
      if (r < 25) begin
        add_word(CH_NUL);
      end else if (r < 35) begin
        add_word(CH_DOT);
      end else if (r < 45) begin
        add_word(CH_DOLLAR);
      end else if (r < 70) begin
        add_text(int_word());
      end else if (r < 85) begin
        case ($urandom_range(0, 3))
          0: add_byte(CH_COLON);
          1: add_byte(CH_COMMA);
          2: add_byte(CH_LPAREN);
          default: add_byte(CH_RPAREN);
        endcase
      end else if (r < 92) begin
        add_text(broken_number());
      end else begin
        for (int i = $urandom_range(1, 4); i > 0; i--) add_byte(8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 9) != 0) begin
        for (int i = $urandom_range(1, 2); i > 0; i--) add_byte(blank_byte());
      end
    end
    if ($urandom_range(0, 4) == 0) add_byte(blank_byte());
  endfunction

  task automatic send_char(input logic [7:0] c, input logic [15:0] ln, input logic lst);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      chars_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    chars_if.valid       <= 1'b1;
    chars_if.ch          <= c;
    chars_if.line_number <= ln;
    chars_if.line_last   <= lst;
    do @(posedge clk); while (chars_if.ready !== 1'b1);
    sb.take_char(c, ln, lst);
  endtask

  task automatic send_line(input logic [15:0] ln, input bit vary_line);
    int count;
    if (line_text.size() == 0) add_byte(CH_SPACE);
    count = line_text.size();
    for (int i = 0; i < count; i++) begin
      send_char(line_text[i], vary_line ? 16'($urandom_range(0, 65535)) : ln, i == count - 1);
    end
    line_text.delete();
  endtask

  task automatic wait_for_tokens();
    @(negedge clk);
    chars_if.valid <= 1'b0;
    while (sb.tokens_due.size() != 0) @(posedge clk);
  endtask

  task automatic run_directed();
    add_text("main: .globl $sp,(lw)");
    send_line(16'd0, 1'b0);
    add_text("0 -0 +7 0x1F 0XaB 017 42 -9223372036854775808 9223372036854775807 ");
    add_text("0x7fffffffffffffff 0777777777777777777777");
    send_line(16'hFFFF, 1'b0);
    add_text("9223372036854775808 -9223372036854775809 0x8000000000000000 ");
    add_text("01000000000000000000000 18446744073709551616");
    send_line(16'h5A5A, 1'b0);
    add_text("+ - 0x 08 09 0x1g 1a --1 . $");
    send_line(16'hA5A5, 1'b0);
    add_text("a");
    add_byte(CH_NUL);
    add_text("b");
    add_byte(CH_TAB);
    add_text("c");
    add_byte(CH_LF);
    add_text("d");
    add_byte(CH_VT);
    add_text("e");
    add_byte(CH_FF);
    add_text("f");
    add_byte(CH_CR);
    add_text("g ");
    add_byte(8'h80);
    add_text("z");
    add_byte(8'hFF);
    add_byte(CH_NUL);
    send_line(16'd1, 1'b0);
    add_text("abc  ");
    send_line(16'd2, 1'b0);
    for (int i = 0; i < 70; i++) add_byte(CH_ZERO);
    add_text("z $");
    for (int i = 0; i < 70; i++) add_byte(8'h72);
    add_byte(CH_SPACE);
    for (int i = 0; i < 70; i++) add_byte(CH_NINE);
    add_text(" q");
    send_line(16'd3, 1'b0);
    add_byte(CH_COLON);
    send_line(16'd4, 1'b0);
    for (int i = 0; i < 120; i++) add_byte(CH_SPACE);
    add_text("abc,d:e");
    send_line(16'd5, 1'b0);
  endtask

  initial begin : stimulus
    int sent;
    int next_pause;
    sb = new();
    chars_if.valid       = 1'b0;
    chars_if.ch          = 8'h00;
    chars_if.line_number = 16'h0000;
    chars_if.line_last   = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    run_directed();
    wait_for_tokens();
    sent = 0;
    next_pause = 400;
    while (sent < RANDOM_ITEMS) begin
      build_random_line();
      sent += line_text.size();
      send_line(16'($urandom_range(0, 65535)), $urandom_range(0, 9) == 0);
      if (sent >= next_pause) begin
        wait_for_tokens();
        next_pause += 400;
      end
    end
    wait_for_tokens();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin : token_sink
    int unsigned stall;
    int unsigned r;
    int unsigned cycles;
    stall = 0;
    cycles = 0;
    tokens_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      cycles++;
      if (cycles % 300 == 0) calm = ($urandom_range(0, 3) == 0);
      if (stall > 0) begin
        stall--;
        tokens_if.ready <= 1'b0;
      end else if (calm) begin
        tokens_if.ready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          tokens_if.ready <= 1'b1;
        end else begin
          stall = (r < 95) ? $urandom_range(0, 2) : $urandom_range(10, 50);
          tokens_if.ready <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : token_monitor
    token_t got;
    if (!rst && tokens_if.valid === 1'b1 && tokens_if.ready === 1'b1) begin
      got.kind         = kind_t'(tokens_if.kind);
      got.token_line   = tokens_if.token_line;
      got.column       = tokens_if.column;
      got.length       = tokens_if.length;
      got.ends_line    = tokens_if.ends_line;
      got.last_of_item = tokens_if.last_of_item;
      sb.check_token(got);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((chars_if.valid === 1'b1 && chars_if.ready === 1'b1) ||
          (tokens_if.valid === 1'b1 && tokens_if.ready === 1'b1)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule

>>> filelist.f
src/atk_pkg.sv
src/atk_char_if.sv
src/atk_token_if.sv
src/atk_fifo.sv
src/atk_front.sv
src/atk_back.sv
src/atk_emit.sv
src/assembly_line_tokenizer_top.sv
tb/tb_assembly_line_tokenizer_top.sv
